@@ rtl/dbd_pkg.sv @@
package dbd_pkg;

    // Field widths
    localparam int COORD_W = 24;
    localparam int SCORE_W = 16;
    localparam int CLSIN_W = 3;
    localparam int CLS_W   = 2;
    localparam int MASK_W  = 3;
    localparam int GAIN_W  = 32;
    localparam int OFF_W   = 24;
    localparam int NORM_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Corner at Q.13 (twice the Q12.12 value): 2*a +/- c needs two more bits
    localparam int CORNER_W = COORD_W + 2;

    // Half-width split of the gain multiply
    localparam int GAIN_HALF_W = GAIN_W / 2;

    // Mapped value is Q.45; rounding drops 29 bits to reach Q0.16
    localparam int ROUND_SHIFT = 29;

    // Coordinates with every magnitude at or below 1.5 (Q12.12) are normalized
    localparam int NORM_LIMIT = 6144;

    // Function codes
    localparam logic FUNC_RAW = 1'b0;
    localparam logic FUNC_E2E = 1'b1;

    // Class codes
    localparam logic [CLS_W-1:0] CLS_FEMALE = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MALE   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_OTHER  = 2'd2;
    localparam logic [CLSIN_W-1:0] CLS_MAX_IN = 3'd2;

    // Register reset values
    localparam logic [SCORE_W-1:0] THR_RESET  = 16'd32768;
    localparam logic [MASK_W-1:0]  MASK_RESET = 3'd3;
    localparam logic [GAIN_W-1:0]  GAIN_RESET = 32'd6710886;
    localparam logic [OFF_W-1:0]   OFF_RESET  = 24'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEMALE_THR = 3'd0,
        CFG_MALE_THR   = 3'd1,
        CFG_OTHER_THR  = 3'd2,
        CFG_BLUR_MASK  = 3'd3,
        CFG_X_GAIN     = 3'd4,
        CFG_X_OFFSET   = 3'd5,
        CFG_Y_GAIN     = 3'd6,
        CFG_Y_OFFSET   = 3'd7
    } t_cfg_idx;

    // Load enables for the three stages of the edge mapper
    typedef struct packed {
        logic mul;
        logic sum;
        logic rnd;
    } t_stage_en;

endpackage

@@ rtl/dbd_if.sv @@
// Candidate input channel
interface dbd_in_if import dbd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic signed [COORD_W-1:0]  coord_a;
    logic signed [COORD_W-1:0]  coord_b;
    logic signed [COORD_W-1:0]  coord_c;
    logic signed [COORD_W-1:0]  coord_d;
    logic [SCORE_W-1:0]         score_0;
    logic [SCORE_W-1:0]         score_1;
    logic [SCORE_W-1:0]         score_2;
    logic [CLSIN_W-1:0]         class_index;

    modport source (
        output valid, func, coord_a, coord_b, coord_c, coord_d,
               score_0, score_1, score_2, class_index,
        input  ready
    );
    modport sink (
        input  valid, func, coord_a, coord_b, coord_c, coord_d,
               score_0, score_1, score_2, class_index,
        output ready
    );
endinterface

// Detection output channel
interface dbd_out_if import dbd_pkg::*;;
    logic               valid;
    logic               ready;
    logic [NORM_W-1:0]  x_min;
    logic [NORM_W-1:0]  y_min;
    logic [NORM_W-1:0]  x_max;
    logic [NORM_W-1:0]  y_max;
    logic [SCORE_W-1:0] confidence;
    logic [CLS_W-1:0]   det_class;
    logic               blur;

    modport source (
        output valid, x_min, y_min, x_max, y_max, confidence, det_class, blur,
        input  ready
    );
    modport sink (
        input  valid, x_min, y_min, x_max, y_max, confidence, det_class, blur,
        output ready
    );
endinterface

// Configuration write channel
interface dbd_cfg_if import dbd_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ rtl/detection_box_decoder_unit.sv @@
// Detection box decoder: one candidate in, zero or one box out.
// A result passes the stage registers in order: decode, model scale,
// gain partials, sum, round/clamp, output register. Each stage advances on its own
// ready; throughput is one candidate per cycle unless the output stalls.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module detection_box_decoder_unit import dbd_pkg::*; #(
    parameter int MODEL_WIDTH  = 640,
    parameter int MODEL_HEIGHT = 640
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dbd_in_if.sink  i_in,
    dbd_cfg_if.sink i_cfg,
    dbd_out_if.source o_out
);

    localparam int MAX_DIM = (MODEL_WIDTH > MODEL_HEIGHT) ? MODEL_WIDTH : MODEL_HEIGHT;
    localparam int SW = CORNER_W + $clog2(MAX_DIM + 1);
    localparam logic signed [SW-1:0] X_DIM = SW'(MODEL_WIDTH);
    localparam logic signed [SW-1:0] Y_DIM = SW'(MODEL_HEIGHT);
    localparam logic signed [COORD_W-1:0] LIM_P = COORD_W'(NORM_LIMIT);
    localparam logic signed [COORD_W-1:0] LIM_N = -COORD_W'(NORM_LIMIT);

    // Configuration registers
    logic [SCORE_W-1:0]       r_thr_female;
    logic [SCORE_W-1:0]       r_thr_male;
    logic [SCORE_W-1:0]       r_thr_other;
    logic [MASK_W-1:0]        r_blur_mask;
    logic [GAIN_W-1:0]        r_x_gain;
    logic signed [OFF_W-1:0]  r_x_offset;
    logic [GAIN_W-1:0]        r_y_gain;
    logic signed [OFF_W-1:0]  r_y_offset;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_female <= THR_RESET;
            r_thr_male   <= THR_RESET;
            r_thr_other  <= THR_RESET;
            r_blur_mask  <= MASK_RESET;
            r_x_gain     <= GAIN_RESET;
            r_x_offset   <= OFF_RESET;
            r_y_gain     <= GAIN_RESET;
            r_y_offset   <= OFF_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FEMALE_THR: r_thr_female <= i_cfg.data[SCORE_W-1:0];
                CFG_MALE_THR:   r_thr_male   <= i_cfg.data[SCORE_W-1:0];
                CFG_OTHER_THR:  r_thr_other  <= i_cfg.data[SCORE_W-1:0];
                CFG_BLUR_MASK:  r_blur_mask  <= i_cfg.data[MASK_W-1:0];
                CFG_X_GAIN:     r_x_gain     <= i_cfg.data[GAIN_W-1:0];
                CFG_X_OFFSET:   r_x_offset   <= i_cfg.data[OFF_W-1:0];
                CFG_Y_GAIN:     r_y_gain     <= i_cfg.data[GAIN_W-1:0];
                CFG_Y_OFFSET:   r_y_offset   <= i_cfg.data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline valid bits and per-stage ready chain
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid, r_s6_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    always_comb begin
        rdy6 = !r_s6_valid || o_out.ready;
        rdy5 = !r_s5_valid || rdy6;
        rdy4 = !r_s4_valid || rdy5;
        rdy3 = !r_s3_valid || rdy4;
        rdy2 = !r_s2_valid || rdy3;
        rdy1 = !r_s1_valid || rdy2;
    end

    assign i_in.ready = rdy1;

    // Stage 1: class pick, threshold and shape checks, corners at Q.13
    logic [CLS_W-1:0]          n_s1_cls;
    logic [SCORE_W-1:0]        n_s1_conf;
    logic [SCORE_W-1:0]        thr;
    logic                      n_s1_keep;
    logic                      n_s1_norm;
    logic                      n_s1_blur;
    logic signed [CORNER_W-1:0] ca, cb, cc, cd;
    logic signed [CORNER_W-1:0] n_s1_corner [4];

    always_comb begin
        ca = CORNER_W'(i_in.coord_a);
        cb = CORNER_W'(i_in.coord_b);
        cc = CORNER_W'(i_in.coord_c);
        cd = CORNER_W'(i_in.coord_d);

        // winning class: first maximal score in raw mode
        if (i_in.func == FUNC_RAW) begin
            n_s1_cls  = CLS_FEMALE;
            n_s1_conf = i_in.score_0;
            if (i_in.score_1 > i_in.score_0) begin
                n_s1_cls  = CLS_MALE;
                n_s1_conf = i_in.score_1;
            end
            if (i_in.score_2 > n_s1_conf) begin
                n_s1_cls  = CLS_OTHER;
                n_s1_conf = i_in.score_2;
            end
        end else begin
            n_s1_cls  = i_in.class_index[CLS_W-1:0];
            n_s1_conf = i_in.score_0;
        end

        case (n_s1_cls)
            CLS_FEMALE: thr = r_thr_female;
            CLS_MALE:   thr = r_thr_male;
            default:    thr = r_thr_other;
        endcase

        if (i_in.func == FUNC_RAW) begin
            n_s1_keep = (n_s1_conf >= thr) && (i_in.coord_c > 0) && (i_in.coord_d > 0);
            n_s1_corner[0] = (ca <<< 1) - cc;
            n_s1_corner[1] = (cb <<< 1) - cd;
            n_s1_corner[2] = (ca <<< 1) + cc;
            n_s1_corner[3] = (cb <<< 1) + cd;
        end else begin
            n_s1_keep = (i_in.class_index <= CLS_MAX_IN) && (n_s1_conf >= thr)
                        && (i_in.coord_c > i_in.coord_a) && (i_in.coord_d > i_in.coord_b);
            n_s1_corner[0] = ca <<< 1;
            n_s1_corner[1] = cb <<< 1;
            n_s1_corner[2] = cc <<< 1;
            n_s1_corner[3] = cd <<< 1;
        end

        // normalized when every magnitude is at most 1.5
        n_s1_norm = (i_in.coord_a <= LIM_P) && (i_in.coord_a >= LIM_N)
                    && (i_in.coord_b <= LIM_P) && (i_in.coord_b >= LIM_N)
                    && (i_in.coord_c <= LIM_P) && (i_in.coord_c >= LIM_N)
                    && (i_in.coord_d <= LIM_P) && (i_in.coord_d >= LIM_N);

        n_s1_blur = r_blur_mask[n_s1_cls];
    end

    logic signed [CORNER_W-1:0] r_s1_corner [4];
    logic                       r_s1_norm;
    logic [SCORE_W-1:0]         r_s1_conf, r_s2_conf, r_s3_conf, r_s4_conf, r_s5_conf;
    logic [CLS_W-1:0]           r_s1_cls, r_s2_cls, r_s3_cls, r_s4_cls, r_s5_cls;
    logic                       r_s1_blur, r_s2_blur, r_s3_blur, r_s4_blur, r_s5_blur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rdy1) begin
            r_s1_valid <= i_in.valid && n_s1_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_corner <= n_s1_corner;
            r_s1_norm   <= n_s1_norm;
            r_s1_conf   <= n_s1_conf;
            r_s1_cls    <= n_s1_cls;
            r_s1_blur   <= n_s1_blur;
        end
    end

    // Stage 2: scale normalized corners to model pixels
    logic signed [SW-1:0] ext_corner [4];
    logic signed [SW-1:0] n_s2_edge [4];
    logic signed [SW-1:0] r_s2_edge [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ext_corner[k] = SW'(r_s1_corner[k]);
            if (!r_s1_norm) begin
                n_s2_edge[k] = ext_corner[k];
            end else if (k % 2 == 0) begin
                n_s2_edge[k] = ext_corner[k] * X_DIM;
            end else begin
                n_s2_edge[k] = ext_corner[k] * Y_DIM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_edge <= n_s2_edge;
            r_s2_conf <= r_s1_conf;
            r_s2_cls  <= r_s1_cls;
            r_s2_blur <= r_s1_blur;
        end
    end

    // Stages 3 to 5: edge mapping, side data follows
    t_stage_en           edge_en;
    logic [NORM_W-1:0]   edge_norm [4];

    assign edge_en = '{mul: rdy3, sum: rdy4, rnd: rdy5};

    for (genvar g = 0; g < 4; g++) begin : g_edge
        dbd_edge_map #(
            .SW (SW)
        ) u_edge_map (
            .i_clk    (i_clk),
            .i_en     (edge_en),
            .i_edge   (r_s2_edge[g]),
            .i_gain   ((g % 2 == 0) ? r_x_gain : r_y_gain),
            .i_offset ((g % 2 == 0) ? r_x_offset : r_y_offset),
            .o_norm   (edge_norm[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (rdy3) r_s3_valid <= r_s2_valid;
            if (rdy4) r_s4_valid <= r_s3_valid;
            if (rdy5) r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_conf <= r_s2_conf;
            r_s3_cls  <= r_s2_cls;
            r_s3_blur <= r_s2_blur;
        end
        if (rdy4) begin
            r_s4_conf <= r_s3_conf;
            r_s4_cls  <= r_s3_cls;
            r_s4_blur <= r_s3_blur;
        end
        if (rdy5) begin
            r_s5_conf <= r_s4_conf;
            r_s5_cls  <= r_s4_cls;
            r_s5_blur <= r_s4_blur;
        end
    end

    // Stage 6: drop empty boxes, output register
    logic              s6_nonempty;
    logic [NORM_W-1:0] r_s6_x_min, r_s6_y_min, r_s6_x_max, r_s6_y_max;
    logic [SCORE_W-1:0] r_s6_conf;
    logic [CLS_W-1:0]  r_s6_cls;
    logic              r_s6_blur;

    assign s6_nonempty = (edge_norm[2] > edge_norm[0]) && (edge_norm[3] > edge_norm[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (rdy6) begin
            r_s6_valid <= r_s5_valid && s6_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_s6_x_min <= edge_norm[0];
            r_s6_y_min <= edge_norm[1];
            r_s6_x_max <= edge_norm[2];
            r_s6_y_max <= edge_norm[3];
            r_s6_conf  <= r_s5_conf;
            r_s6_cls   <= r_s5_cls;
            r_s6_blur  <= r_s5_blur;
        end
    end

    assign o_out.valid      = r_s6_valid;
    assign o_out.x_min      = r_s6_x_min;
    assign o_out.y_min      = r_s6_y_min;
    assign o_out.x_max      = r_s6_x_max;
    assign o_out.y_max      = r_s6_y_max;
    assign o_out.confidence = r_s6_conf;
    assign o_out.det_class  = r_s6_cls;
    assign o_out.blur       = r_s6_blur;

endmodule

@@ rtl/dbd_edge_map.sv @@
// Maps one corner: edge*gain + offset*2^29, then round, clamp to Q0.16.
module dbd_edge_map import dbd_pkg::*; #(
    parameter int SW = 39
) (
    input  logic                    i_clk,
    input  t_stage_en               i_en,
    input  logic signed [SW-1:0]    i_edge,
    input  logic [GAIN_W-1:0]       i_gain,
    input  logic signed [OFF_W-1:0] i_offset,
    output logic [NORM_W-1:0]       o_norm
);

    localparam int PW = SW + GAIN_HALF_W + 1;
    localparam int TW = SW + GAIN_W + 1;
    localparam int SAT_LSB = ROUND_SHIFT + NORM_W;
    localparam logic signed [TW-1:0] HALF_LSB = TW'(1) <<< (ROUND_SHIFT - 1);

    logic signed [PW-1:0] edge_ext;
    logic signed [PW-1:0] gain_lo;
    logic signed [PW-1:0] gain_hi;
    logic signed [PW-1:0] r_p_lo, n_p_lo;
    logic signed [PW-1:0] r_p_hi, n_p_hi;
    logic signed [TW-1:0] r_t, n_t;
    logic signed [TW-1:0] rounded;
    logic                 pos;
    logic                 sat;
    logic [NORM_W-1:0]    r_norm, n_norm;

    // Partial products over the two gain halves
    always_comb begin
        edge_ext = PW'(i_edge);
        gain_lo  = PW'({1'b0, i_gain[GAIN_HALF_W-1:0]});
        gain_hi  = PW'({1'b0, i_gain[GAIN_W-1:GAIN_HALF_W]});
        n_p_lo   = edge_ext * gain_lo;
        n_p_hi   = edge_ext * gain_hi;
    end

    // Combine partials and add offset at Q.45
    always_comb begin
        n_t = (TW'(r_p_hi) <<< GAIN_HALF_W) + TW'(r_p_lo) + (TW'(i_offset) <<< ROUND_SHIFT);
    end

    // Round half up, floor at zero, saturate at full scale
    always_comb begin
        pos     = !r_t[TW-1] && (r_t != '0);
        rounded = r_t + HALF_LSB;
        sat     = |rounded[TW-1:SAT_LSB];
        if (!pos) begin
            n_norm = '0;
        end else if (sat) begin
            n_norm = '1;
        end else begin
            n_norm = rounded[SAT_LSB-1:ROUND_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p_lo <= n_p_lo;
            r_p_hi <= n_p_hi;
        end
        if (i_en.sum) begin
            r_t <= n_t;
        end
        if (i_en.rnd) begin
            r_norm <= n_norm;
        end
    end

    assign o_norm = r_norm;

endmodule

@@ tb/sv/detection_box_decoder_unit_test.sv @@
`timescale 1ns / 100ps

module detection_box_decoder_unit_test import dbd_pkg::*;;

    localparam int MODEL_W        = 640;
    localparam int MODEL_H        = 640;
    localparam int PIPE_DRAIN     = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PCT       = 25;

    // One candidate as it goes over the input channel
    typedef struct packed {
        bit                       func;
        bit signed [COORD_W-1:0]  coord_a;
        bit signed [COORD_W-1:0]  coord_b;
        bit signed [COORD_W-1:0]  coord_c;
        bit signed [COORD_W-1:0]  coord_d;
        bit [SCORE_W-1:0]         score_0;
        bit [SCORE_W-1:0]         score_1;
        bit [SCORE_W-1:0]         score_2;
        bit [CLSIN_W-1:0]         class_index;
    } t_cand;

    // One decoded detection
    typedef struct packed {
        bit [NORM_W-1:0]  x_min;
        bit [NORM_W-1:0]  y_min;
        bit [NORM_W-1:0]  x_max;
        bit [NORM_W-1:0]  y_max;
        bit [SCORE_W-1:0] confidence;
        bit [CLS_W-1:0]   det_class;
        bit               blur;
    } t_det;

    // Directed row: typed rows carry their own answer, the rest use decode_box
    typedef struct {
        t_cand cand;
        bit    typed;
        bit    hit;
        t_det  box;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic det_ready = 1'b0;
    bit   no_stall = 1'b0;

    dbd_in_if  in_if ();
    dbd_cfg_if cfg_if ();
    dbd_out_if out_if ();

    assign out_if.ready = det_ready;

    detection_box_decoder_unit #(
        .MODEL_WIDTH  (MODEL_W),
        .MODEL_HEIGHT (MODEL_H)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the register file
    bit [SCORE_W-1:0]       thr_q16 [3];
    bit [MASK_W-1:0]        blur_mask;
    bit [GAIN_W-1:0]        gain_x;
    bit [GAIN_W-1:0]        gain_y;
    bit signed [OFF_W-1:0]  off_x;
    bit signed [OFF_W-1:0]  off_y;

    t_det     pending_boxes [$];
    t_dir_row dir_rows [$];

    int n_items;
    int n_dir;
    int n_boxes;
    int n_fail;
    int n_settings;
    int idle_cycles;

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // corner (Q.13) * gain + offset, rounded to Q0.16 and clamped to 0..1
    function automatic bit [NORM_W-1:0] map_edge(longint corner, bit [GAIN_W-1:0] gain,
                                                 bit signed [OFF_W-1:0] off);
        longint t;
        t = corner * longint'({32'd0, gain}) + longint'(off) * (longint'(1) << ROUND_SHIFT);
        if (t <= 0)
            return '0;
        t = (t + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        return (t > 65535) ? 16'hFFFF : t[NORM_W-1:0];
    endfunction

    // Expected detection for one candidate; returns 0 when it is dropped
    function automatic bit decode_box(input t_cand c, output t_det r);
        longint a, b, w, h, big, x1, x2, y1, y2;
        bit [CLS_W-1:0]   cls;
        bit [SCORE_W-1:0] conf;
        r = '0;
        a = longint'($signed(c.coord_a));
        b = longint'($signed(c.coord_b));
        w = longint'($signed(c.coord_c));
        h = longint'($signed(c.coord_d));
        conf = c.score_0;
        if (c.func == FUNC_RAW) begin
            // first maximal score wins
            cls = CLS_FEMALE;
            if (c.score_1 > conf) begin
                cls = CLS_MALE;
                conf = c.score_1;
            end
            if (c.score_2 > conf) begin
                cls = CLS_OTHER;
                conf = c.score_2;
            end
            if (conf < thr_q16[cls])
                return 1'b0;
            if (w <= 0 || h <= 0)
                return 1'b0;
        end else begin
            if (c.class_index > CLS_MAX_IN)
                return 1'b0;
            cls = c.class_index[CLS_W-1:0];
            if (conf < thr_q16[cls])
                return 1'b0;
            if (w <= a || h <= b)
                return 1'b0;
        end
        big = mag64(a);
        if (mag64(b) > big) big = mag64(b);
        if (mag64(w) > big) big = mag64(w);
        if (mag64(h) > big) big = mag64(h);
        if (c.func == FUNC_RAW) begin
            x1 = 2 * a - w;
            x2 = 2 * a + w;
            y1 = 2 * b - h;
            y2 = 2 * b + h;
        end else begin
            x1 = 2 * a;
            y1 = 2 * b;
            x2 = 2 * w;
            y2 = 2 * h;
        end
        // normalized coordinates get scaled to model pixels
        if (big <= NORM_LIMIT) begin
            x1 = x1 * MODEL_W;
            x2 = x2 * MODEL_W;
            y1 = y1 * MODEL_H;
            y2 = y2 * MODEL_H;
        end
        r.x_min = map_edge(x1, gain_x, off_x);
        r.y_min = map_edge(y1, gain_y, off_y);
        r.x_max = map_edge(x2, gain_x, off_x);
        r.y_max = map_edge(y2, gain_y, off_y);
        if (r.x_max <= r.x_min || r.y_max <= r.y_min)
            return 1'b0;
        r.confidence = conf;
        r.det_class = cls;
        r.blur = blur_mask[cls];
        return 1'b1;
    endfunction

    function automatic t_cand mk_cand(bit f, int a, int b, int c, int d,
                                      int s0, int s1, int s2, int ci);
        t_cand r;
        r.func = f;
        r.coord_a = a[COORD_W-1:0];
        r.coord_b = b[COORD_W-1:0];
        r.coord_c = c[COORD_W-1:0];
        r.coord_d = d[COORD_W-1:0];
        r.score_0 = s0[SCORE_W-1:0];
        r.score_1 = s1[SCORE_W-1:0];
        r.score_2 = s2[SCORE_W-1:0];
        r.class_index = ci[CLSIN_W-1:0];
        return r;
    endfunction

    function automatic t_det mk_box(int x0, int y0, int x1, int y1, int conf,
                                    bit [CLS_W-1:0] cls, bit blur);
        t_det r;
        r.x_min = x0[NORM_W-1:0];
        r.y_min = y0[NORM_W-1:0];
        r.x_max = x1[NORM_W-1:0];
        r.y_max = y1[NORM_W-1:0];
        r.confidence = conf[SCORE_W-1:0];
        r.det_class = cls;
        r.blur = blur;
        return r;
    endfunction

    function automatic t_dir_row row_pred(t_cand c);
        t_dir_row r;
        r.cand = c;
        r.typed = 1'b0;
        r.hit = 1'b0;
        r.box = '0;
        return r;
    endfunction

    function automatic t_dir_row row_none(t_cand c);
        t_dir_row r;
        r = row_pred(c);
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic t_dir_row row_box(t_cand c, t_det b);
        t_dir_row r;
        r = row_pred(c);
        r.typed = 1'b1;
        r.hit = 1'b1;
        r.box = b;
        return r;
    endfunction

    // Append one directed row to the stimulus table
    function automatic void add_row(t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Queue one expected box behind those already waiting
    function automatic void expect_box(t_det b);
        pending_boxes.insert(pending_boxes.size(), b);
    endfunction

    // Random candidate: mostly plausible boxes, some full-range noise
    function automatic t_cand gen_cand();
        t_cand c;
        int kind, span, x, y, w, h, k, t;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            c.func = 1'($urandom);
            c.coord_a = COORD_W'($urandom);
            c.coord_b = COORD_W'($urandom);
            c.coord_c = COORD_W'($urandom);
            c.coord_d = COORD_W'($urandom);
            c.score_0 = SCORE_W'($urandom);
            c.score_1 = SCORE_W'($urandom);
            c.score_2 = SCORE_W'($urandom);
            c.class_index = CLSIN_W'($urandom);
            return c;
        end
        // normalized units (1.0 = 4096) or model pixels
        span = ($urandom_range(0, 1) == 1) ? 4096 : MODEL_W * 4096;
        x = $urandom_range(0, span);
        y = $urandom_range(0, span);
        w = $urandom_range(1, span / 2);
        h = $urandom_range(1, span / 2);
        if ($urandom_range(0, 7) == 0) x = x - span / 8;
        if ($urandom_range(0, 7) == 0) y = y - span / 8;
        c.func = 1'($urandom_range(0, 1));
        if (c.func == FUNC_RAW) begin
            if (kind < 14) w = -int'($urandom_range(0, 8));
            if (kind >= 14 && kind < 18) h = -int'($urandom_range(0, 8));
            c.coord_a = COORD_W'(x);
            c.coord_b = COORD_W'(y);
            c.coord_c = COORD_W'(w);
            c.coord_d = COORD_W'(h);
        end else begin
            c.coord_a = COORD_W'(x);
            c.coord_b = COORD_W'(y);
            c.coord_c = COORD_W'((kind < 14) ? x - w : x + w);
            c.coord_d = COORD_W'((kind >= 14 && kind < 18) ? y - h : y + h);
        end
        c.score_0 = SCORE_W'($urandom);
        c.score_1 = SCORE_W'($urandom);
        c.score_2 = SCORE_W'($urandom);
        // usually lift one score into the passing range
        if ($urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, 2);
            t = ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(32768, 65535);
            if (k == 0) c.score_0 = SCORE_W'(t);
            else if (k == 1) c.score_1 = SCORE_W'(t);
            else c.score_2 = SCORE_W'(t);
        end
        if ($urandom_range(0, 9) == 0) c.score_1 = c.score_0;
        if ($urandom_range(0, 9) == 0) c.score_2 = c.score_1;
        c.class_index = ($urandom_range(0, 9) == 0) ? CLSIN_W'($urandom_range(3, 7))
                                                     : CLSIN_W'($urandom_range(0, 2));
        return c;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endtask

    // Random source-side idle cycles ahead of a transaction
    task automatic idle_gap();
        if (!no_stall) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    // Drive one candidate, then record what it should produce
    task automatic send_cand(t_cand c, bit typed, bit hit, t_det box);
        t_det pred;
        in_if.valid <= 1'b1;
        in_if.func <= c.func;
        in_if.coord_a <= c.coord_a;
        in_if.coord_b <= c.coord_b;
        in_if.coord_c <= c.coord_c;
        in_if.coord_d <= c.coord_d;
        in_if.score_0 <= c.score_0;
        in_if.score_1 <= c.score_1;
        in_if.score_2 <= c.score_2;
        in_if.class_index <= c.class_index;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        n_items++;
        if (typed) begin
            if (hit)
                expect_box(box);
        end else if (decode_box(c, pred)) begin
            expect_box(pred);
        end
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            idle_gap();
            send_cand(gen_cand(), 1'b0, 1'b0, '0);
        end
    endtask

    // Stop the source and let the pipeline empty out
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(t_cfg_idx idx, bit [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        case (idx)
            CFG_FEMALE_THR: thr_q16[CLS_FEMALE] = val[SCORE_W-1:0];
            CFG_MALE_THR:   thr_q16[CLS_MALE] = val[SCORE_W-1:0];
            CFG_OTHER_THR:  thr_q16[CLS_OTHER] = val[SCORE_W-1:0];
            CFG_BLUR_MASK:  blur_mask = val[MASK_W-1:0];
            CFG_X_GAIN:     gain_x = val;
            CFG_X_OFFSET:   off_x = val[OFF_W-1:0];
            CFG_Y_GAIN:     gain_y = val;
            CFG_Y_OFFSET:   off_y = val[OFF_W-1:0];
            default: ;
        endcase
    endtask

    // Reprogram every register once the block has gone idle
    task automatic set_regs(bit [SCORE_W-1:0] t0, bit [SCORE_W-1:0] t1,
                            bit [SCORE_W-1:0] t2, bit [MASK_W-1:0] mask,
                            bit [GAIN_W-1:0] gx, int ox, bit [GAIN_W-1:0] gy, int oy);
        wait_idle();
        write_reg(CFG_FEMALE_THR, 32'(t0));
        write_reg(CFG_MALE_THR, 32'(t1));
        write_reg(CFG_OTHER_THR, 32'(t2));
        write_reg(CFG_BLUR_MASK, 32'(mask));
        write_reg(CFG_X_GAIN, gx);
        write_reg(CFG_X_OFFSET, 32'(ox));
        write_reg(CFG_Y_GAIN, gy);
        write_reg(CFG_Y_OFFSET, 32'(oy));
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    // Sink side: random back-pressure
    always @(posedge i_clk)
        det_ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);

    // Output checker and watchdog
    always @(posedge i_clk) begin : mon
        t_det want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t ns: box with no pending expectation, actual x_min %0d y_min %0d",
                         $time, out_if.x_min, out_if.y_min);
                n_fail++;
            end else begin
                want = pending_boxes.pop_front();
                check_field("x_min", want.x_min, out_if.x_min);
                check_field("y_min", want.y_min, out_if.y_min);
                check_field("x_max", want.x_max, out_if.x_max);
                check_field("y_max", want.y_max, out_if.y_max);
                check_field("confidence", want.confidence, out_if.confidence);
                check_field("det_class", want.det_class, out_if.det_class);
                check_field("blur", want.blur, out_if.blur);
                n_boxes++;
            end
        end
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
            (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles, %0d boxes still pending",
                     $time, idle_cycles, pending_boxes.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Main sequence
    initial begin
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.func <= FUNC_RAW;
        in_if.coord_a <= '0;
        in_if.coord_b <= '0;
        in_if.coord_c <= '0;
        in_if.coord_d <= '0;
        in_if.score_0 <= '0;
        in_if.score_1 <= '0;
        in_if.score_2 <= '0;
        in_if.class_index <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_FEMALE_THR;
        cfg_if.data <= '0;
        idle_cycles = 0;

        // shadow registers start at their reset values
        thr_q16[CLS_FEMALE] = THR_RESET;
        thr_q16[CLS_MALE] = THR_RESET;
        thr_q16[CLS_OTHER] = THR_RESET;
        blur_mask = MASK_RESET;
        gain_x = GAIN_RESET;
        gain_y = GAIN_RESET;
        off_x = OFF_RESET;
        off_y = OFF_RESET;

        // Directed rows, all run with the reset register values
        // unit box in normalized coordinates fills the frame, one per class
        add_row(row_box(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 40000, 0, 0, 0),
                        mk_box(0, 0, 65535, 65535, 40000, CLS_FEMALE, 1'b1)));
        add_row(row_box(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 40000, 0, 0, 1),
                        mk_box(0, 0, 65535, 65535, 40000, CLS_MALE, 1'b1)));
        add_row(row_box(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 40000, 0, 0, 2),
                        mk_box(0, 0, 65535, 65535, 40000, CLS_OTHER, 1'b0)));
        // class index out of range
        add_row(row_none(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 65535, 0, 0, 3)));
        add_row(row_none(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 65535, 0, 0, 7)));
        // one below threshold, then exactly at threshold
        add_row(row_none(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 32767, 0, 0, 0)));
        add_row(row_box(mk_cand(FUNC_E2E, 0, 0, 4096, 4096, 32768, 0, 0, 1),
                        mk_box(0, 0, 65535, 65535, 32768, CLS_MALE, 1'b1)));
        // corners not strictly ordered
        add_row(row_none(mk_cand(FUNC_E2E, 4096, 0, 4096, 4096, 65535, 0, 0, 0)));
        add_row(row_none(mk_cand(FUNC_E2E, 0, 4096, 4096, 2048, 65535, 0, 0, 0)));
        // raw: zero width, negative height, all scores under threshold
        add_row(row_none(mk_cand(FUNC_RAW, 2048, 2048, 0, 4096, 65535, 0, 0, 0)));
        add_row(row_none(mk_cand(FUNC_RAW, 2048, 2048, 4096, -1, 65535, 0, 0, 0)));
        add_row(row_none(mk_cand(FUNC_RAW, 2048, 2048, 2048, 2048,
                                 32767, 32767, 32767, 0)));
        // full-range corners: left/top clamp to zero, right/bottom saturate
        add_row(row_box(mk_cand(FUNC_E2E, -8388608, -8388608, 8388607, 8388607,
                                65535, 65535, 65535, 0),
                        mk_box(0, 0, 65535, 65535, 65535, CLS_FEMALE, 1'b1)));
        // boxes entirely left of the frame, then one entirely right of it
        add_row(row_none(mk_cand(FUNC_RAW, -8388608, -8388608, 8388607, 8388607,
                                 65535, 0, 0, 0)));
        add_row(row_none(mk_cand(FUNC_E2E, -40960, -40960, -4096, -4096,
                                 65535, 0, 0, 0)));
        add_row(row_none(mk_cand(FUNC_E2E, 4000000, 4000000, 5000000, 5000000,
                                 65535, 0, 0, 0)));
        // score ties pick the lowest class; class index is a don't-care in raw mode
        add_row(row_pred(mk_cand(FUNC_RAW, 2048, 2048, 2048, 2048,
                                 50000, 50000, 50000, 7)));
        add_row(row_pred(mk_cand(FUNC_RAW, 320 * 4096, 240 * 4096, 100 * 4096,
                                 80 * 4096, 100, 60000, 60000, 0)));
        add_row(row_pred(mk_cand(FUNC_RAW, 320 * 4096, 240 * 4096, 100 * 4096,
                                 80 * 4096, 0, 65534, 65535, 5)));
        // normalization boundary: exactly 1.5, then just above it
        add_row(row_pred(mk_cand(FUNC_E2E, 0, 0, 6144, 6144, 65535, 0, 0, 0)));
        add_row(row_pred(mk_cand(FUNC_E2E, 0, 0, 6145, 6145, 65535, 0, 0, 0)));
        add_row(row_pred(mk_cand(FUNC_RAW, 8388607, 8388607, 8388607, 8388607,
                                 65535, 65535, 65535, 0)));
        // end-to-end ignores the second and third score
        add_row(row_pred(mk_cand(FUNC_E2E, 100 * 4096, 50 * 4096, 300 * 4096,
                                 400 * 4096, 50000, 65535, 65535, 2)));
        add_row(row_pred(mk_cand(FUNC_RAW, -1024, 1024, 4096, 2048,
                                 40000, 1, 2, 0)));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            idle_gap();
            send_cand(dir_rows[i].cand, dir_rows[i].typed, dir_rows[i].hit, dir_rows[i].box);
        end
        n_dir = n_items;

        // Reset settings, with a long stretch free of stalls in the middle
        run_random(100);
        no_stall <= 1'b1;
        run_random(150);
        no_stall <= 1'b0;
        run_random(100);

        // Extremes: open thresholds, full gain, most negative offsets
        set_regs(16'd0, 16'd0, 16'd0, 3'd7, 32'hFFFF_FFFF, -8388608,
                 32'hFFFF_FFFF, -8388608);
        run_random(120);

        // Extremes: closed thresholds, zero gain, most positive offsets
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0, 32'd0, 8388607, 32'd0, 8388607);
        run_random(60);

        // Random settings around a plausible letterbox transform
        for (int p = 0; p < 3; p++) begin
            set_regs(16'($urandom_range(0, 45000)), 16'($urandom_range(0, 45000)),
                     16'($urandom_range(0, 45000)), 3'($urandom_range(0, 7)),
                     32'($urandom_range(3000000, 14000000)),
                     int'($urandom_range(0, 32768)) - 16384,
                     32'($urandom_range(3000000, 14000000)),
                     int'($urandom_range(0, 32768)) - 16384);
            run_random(280);
        end

        wait_idle();

        $display("summary: %0d candidates (%0d directed) over %0d register settings",
                 n_items, n_dir, n_settings + 1);
        $display("summary: %0d boxes compared, %0d mismatches", n_boxes, n_fail);
        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
